// ----- rtl/lned_pkg.sv -----
// Shared types, codes and echo tables for the line editor receive block.
`default_nettype none

package lned_pkg;

   // Default line store capacity in bytes
   localparam int LINE_CAPACITY = 128;

   // Item operation codes
   localparam logic [1:0] OP_RECV    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   // Terminal characters
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   // Echo sequence kinds
   localparam logic [2:0] KIND_NONE   = 3'd0;  // one result, nothing echoed
   localparam logic [2:0] KIND_CHAR   = 3'd1;  // echo the stored character
   localparam logic [2:0] KIND_EOL    = 3'd2;  // CR LF
   localparam logic [2:0] KIND_PROMPT = 3'd3;  // CR LF '>' space
   localparam logic [2:0] KIND_ERASE  = 3'd4;  // BS space BS

   // Result burst descriptor handed from the editor to the echo sequencer
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic       line_ready;
      logic [6:0] line_length;
      logic       read_sel;
   } desc_type;

   // Index of the final beat of a burst of the given kind
   function automatic logic [1:0] beat_last(input logic [2:0] kind);
      logic [1:0] n;
      case (kind)
         KIND_EOL:    n = 2'd1;
         KIND_PROMPT: n = 2'd3;
         KIND_ERASE:  n = 2'd2;
         default:     n = 2'd0;
      endcase
      return n;
   endfunction

   // Echo byte for one beat of a burst; zero when nothing is echoed
   function automatic logic [7:0] echo_char(input logic [2:0] kind, input logic [7:0] ch,
                                            input logic [1:0] beat);
      logic [7:0] c;
      c = 8'h00;
      case (kind)
         KIND_CHAR: c = ch;
         KIND_EOL:  c = (beat == 2'd0) ? CH_CR : CH_LF;
         KIND_PROMPT: begin
            case (beat)
               2'd0:    c = CH_CR;
               2'd1:    c = CH_LF;
               2'd2:    c = CH_GT;
               default: c = CH_SP;
            endcase
         end
         KIND_ERASE: c = (beat == 2'd1) ? CH_SP : CH_BS;
         default:    c = 8'h00;
      endcase
      return c;
   endfunction

   // True when the kind drives a byte to transmit
   function automatic logic echo_on(input logic [2:0] kind);
      return kind != KIND_NONE;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lned_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lned_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/lned_edit.sv -----
// Input register, line state and editing decisions for the line editor.
`default_nettype none

module lned_edit #(
   parameter int LINE_CAPACITY = lned_pkg::LINE_CAPACITY
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // incoming item
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [1:0]                       in_op,
   input  wire logic [7:0]                       in_byte,
   input  wire logic [6:0]                       in_index,
   // descriptor toward the echo sequencer
   output logic                                  desc_valid,
   input  wire logic                             desc_ready,
   output lned_pkg::desc_type                    desc,
   // line store ports
   output logic                                  store_wr_en,
   output logic [$clog2(LINE_CAPACITY)-1:0]      store_wr_addr,
   output logic [7:0]                            store_wr_data,
   output logic                                  store_rd_en,
   output logic [$clog2(LINE_CAPACITY)-1:0]      store_rd_addr
);

   localparam int AW = $clog2(LINE_CAPACITY);
   localparam logic [AW-1:0] FILL_MAX = AW'(LINE_CAPACITY - 1);

   logic          in_valid_ff;
   logic [1:0]    op_ff;
   logic [7:0]    byte_ff;
   logic [6:0]    index_ff;
   logic [AW-1:0] fill_ff;
   logic [AW-1:0] fill_in;
   logic          ready_ff;
   logic          ready_in;
   logic          fire;
   logic          in_range;
   logic [AW+6:0] index_ext;

   assign fire       = in_valid_ff && desc_ready;
   assign in_ready   = !in_valid_ff || desc_ready;
   assign desc_valid = in_valid_ff;

   // Hold the accepted item until the sequencer takes its descriptor
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         op_ff    <= in_op;
         byte_ff  <= in_byte;
         index_ff <= in_index;
      end
   end

   // Line count and ready flag
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         ready_ff <= 1'b0;
      end else if (fire) begin
         fill_ff  <= fill_in;
         ready_ff <= ready_in;
      end
   end

   assign index_ext = {{AW{1'b0}}, index_ff};
   assign in_range  = 32'(index_ff) < LINE_CAPACITY;

   // Decide the edit, the store access and the echo burst for this item
   always_comb begin
      fill_in       = fill_ff;
      ready_in      = ready_ff;
      desc.kind     = lned_pkg::KIND_NONE;
      desc.ch       = byte_ff;
      desc.read_sel = 1'b0;
      store_wr_en   = 1'b0;
      store_rd_en   = 1'b0;
      case (op_ff)
         lned_pkg::OP_RECV: begin
            if (ready_ff) begin
               desc.kind = lned_pkg::KIND_NONE;
            end else if (byte_ff inside {lned_pkg::CH_CR, lned_pkg::CH_LF}) begin
               if (fill_ff != '0) begin
                  ready_in  = 1'b1;
                  desc.kind = lned_pkg::KIND_EOL;
               end else begin
                  desc.kind = lned_pkg::KIND_PROMPT;
               end
            end else if (byte_ff inside {lned_pkg::CH_BS, lned_pkg::CH_DEL}) begin
               if (fill_ff != '0) begin
                  fill_in   = fill_ff - AW'(1);
                  desc.kind = lned_pkg::KIND_ERASE;
               end
            end else if ((byte_ff inside {[lned_pkg::CH_SP:lned_pkg::CH_TILDE]}) &&
                         (fill_ff < FILL_MAX)) begin
               fill_in     = fill_ff + AW'(1);
               store_wr_en = fire;
               desc.kind   = lned_pkg::KIND_CHAR;
            end
         end
         lned_pkg::OP_RELEASE: begin
            fill_in   = '0;
            ready_in  = 1'b0;
            desc.kind = lned_pkg::KIND_PROMPT;
         end
         lned_pkg::OP_READ: begin
            desc.read_sel = in_range;
            store_rd_en   = fire && in_range;
         end
         default: begin
            desc.kind = lned_pkg::KIND_NONE;
         end
      endcase
      // Report state as it stands after this item
      desc.line_ready  = ready_in;
      desc.line_length = 7'(fill_in);
   end

   assign store_wr_addr = fill_ff;
   assign store_wr_data = byte_ff;
   assign store_rd_addr = index_ext[AW-1:0];

endmodule

`default_nettype wire

// ----- rtl/lned_echo.sv -----
// Result register and beat sequencer that plays out each echo burst.
`default_nettype none

module lned_echo (
   input  wire logic               clock,
   input  wire logic               reset,
   // descriptor from the editor
   input  wire logic               desc_valid,
   output logic                    desc_ready,
   input  wire lned_pkg::desc_type desc,
   // store read data, aligned with the held descriptor
   input  wire logic [7:0]         store_rd_data,
   // result items
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic                    out_echo_valid,
   output logic [7:0]              out_echo_byte,
   output logic [7:0]              out_read_data,
   output logic                    out_line_ready,
   output logic [6:0]              out_line_length,
   output logic                    out_last
);

   logic               valid_ff;
   lned_pkg::desc_type desc_ff;
   logic [1:0]         beat_ff;
   logic               last_beat;

   assign last_beat  = beat_ff == lned_pkg::beat_last(desc_ff.kind);
   assign desc_ready = !valid_ff || (out_ready && last_beat);

   // Load a new burst or advance one beat per taken item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else if (desc_ready) begin
         valid_ff <= desc_valid;
         beat_ff  <= 2'd0;
      end else if (out_ready) begin
         beat_ff  <= beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_ready && desc_valid) begin
         desc_ff <= desc;
      end
   end

   // Drive the current beat
   assign out_valid       = valid_ff;
   assign out_echo_valid  = lned_pkg::echo_on(desc_ff.kind);
   assign out_echo_byte   = lned_pkg::echo_char(desc_ff.kind, desc_ff.ch, beat_ff);
   assign out_read_data   = desc_ff.read_sel ? store_rd_data : 8'h00;
   assign out_line_ready  = desc_ff.line_ready;
   assign out_line_length = desc_ff.line_length;
   assign out_last        = last_beat;

endmodule

`default_nettype wire

// ----- rtl/line_editor_receive.sv -----
// Line editor receive block: item register, editor, line store and echo sequencer.
// An accepted item waits in the item register until the echo sequencer loads its descriptor
// into the result register, which offers the item's results.
// Throughput: one item per cycle for items with a single result while rsp_tready is high; an
// item with up to four results holds the result port until its last result is taken.
// Reset (synchronous, active high) empties both registers and clears the count and flag.
`default_nettype none

module line_editor_receive #(
   parameter int LINE_CAPACITY = lned_pkg::LINE_CAPACITY
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // op[1:0], rx_byte[9:2], read_index[16:10], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // echo_byte[7:0], read_data[15:8],
                                         // line_ready[16], line_length[23:17]
   output logic             rsp_tuser,   // echo_valid
   output logic             rsp_tlast
);

   localparam int AW = $clog2(LINE_CAPACITY);

   logic               desc_valid;
   logic               desc_ready;
   lned_pkg::desc_type desc;
   logic               store_wr_en;
   logic [AW-1:0]      store_wr_addr;
   logic [7:0]         store_wr_data;
   logic               store_rd_en;
   logic [AW-1:0]      store_rd_addr;
   logic [7:0]         store_rd_data;
   logic [7:0]         echo_byte;
   logic [7:0]         read_data;
   logic               line_ready;
   logic [6:0]         line_length;

   lned_edit #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_edit (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_op         (req_tdata[1:0]),
      .in_byte       (req_tdata[9:2]),
      .in_index      (req_tdata[16:10]),
      .desc_valid    (desc_valid),
      .desc_ready    (desc_ready),
      .desc          (desc),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr)
   );

   lned_ram #(
      .WIDTH(8),
      .DEPTH(LINE_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   lned_echo u_echo (
      .clock           (clock),
      .reset           (reset),
      .desc_valid      (desc_valid),
      .desc_ready      (desc_ready),
      .desc            (desc),
      .store_rd_data   (store_rd_data),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_echo_valid  (rsp_tuser),
      .out_echo_byte   (echo_byte),
      .out_read_data   (read_data),
      .out_line_ready  (line_ready),
      .out_line_length (line_length),
      .out_last        (rsp_tlast)
   );

   // Pack result fields
   assign rsp_tdata = {line_length, line_ready, read_data, echo_byte};

`ifndef SYNTHESIS
   // Store writes only come from a stored character as its descriptor moves on
   a_write_on_char: assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (desc_valid && desc_ready && desc.kind == lned_pkg::KIND_CHAR))
      else $error("line store written outside a character store");

   // One item never reads and writes the store at once
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(store_wr_en && store_rd_en))
      else $error("line store read and written in the same cycle");

   // A result with nothing to echo is always the only one of its item
   a_silent_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("silent result is not the final one");

   // Reset empties the result register
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_line_editor_receive.sv -----
// Testbench for line_editor_receive: directed and random items checked against a built-in predictor.
`default_nettype none

module tb_line_editor_receive;

   // Op code the block does not define; it must answer with one silent result
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 380;
   localparam int QUIET_LIMIT = 500;
   localparam int TAIL_CYCLES = 16;

   // One expected result
   typedef struct packed {
      logic       echo_on;
      logic [7:0] echo_byte;
      logic [7:0] read_data;
      logic       line_ready;
      logic [6:0] line_length;
      logic       tail;
   } echo_rec_type;

   // Editor predictor with the queue of results still owed by the block
   class echo_tracker;
      logic [7:0]   line_copy[lned_pkg::LINE_CAPACITY];
      int           fill;
      int           peak_fill;
      bit           ready;
      echo_rec_type echo_due[$];
      int           errors;
      int           n_items;
      int           n_results;
      int           n_lines;

      function new();
         fill = 0;
         peak_fill = 0;
         ready = 0;
         errors = 0;
         n_items = 0;
         n_results = 0;
         n_lines = 0;
      endfunction

      // Work out the results of one accepted item and queue them
      function void take_item(logic [1:0] op, logic [7:0] b, logic [6:0] idx);
         logic [7:0]   seq[4];
         int           n;
         logic         on;
         logic [7:0]   rd;
         echo_rec_type rec;
         n = 1;
         on = 1'b0;
         rd = 8'h00;
         seq[0] = 8'h00;
         n_items++;
         case (op)
            lned_pkg::OP_RECV: begin
               if (ready) begin
                  n = 1;
               end else if (b == lned_pkg::CH_CR || b == lned_pkg::CH_LF) begin
                  on = 1'b1;
                  seq[0] = lned_pkg::CH_CR;
                  seq[1] = lned_pkg::CH_LF;
                  if (fill > 0) begin
                     ready = 1;
                     n_lines++;
                     n = 2;
                  end else begin
                     seq[2] = lned_pkg::CH_GT;
                     seq[3] = lned_pkg::CH_SP;
                     n = 4;
                  end
               end else if (b == lned_pkg::CH_BS || b == lned_pkg::CH_DEL) begin
                  if (fill > 0) begin
                     fill--;
                     on = 1'b1;
                     seq[0] = lned_pkg::CH_BS;
                     seq[1] = lned_pkg::CH_SP;
                     seq[2] = lned_pkg::CH_BS;
                     n = 3;
                  end
               end else if (b >= lned_pkg::CH_SP && b <= lned_pkg::CH_TILDE &&
                            fill < lned_pkg::LINE_CAPACITY - 1) begin
                  line_copy[fill] = b;
                  fill++;
                  if (fill > peak_fill) peak_fill = fill;
                  on = 1'b1;
                  seq[0] = b;
               end
            end
            lned_pkg::OP_RELEASE: begin
               fill = 0;
               ready = 0;
               on = 1'b1;
               seq[0] = lned_pkg::CH_CR;
               seq[1] = lned_pkg::CH_LF;
               seq[2] = lned_pkg::CH_GT;
               seq[3] = lned_pkg::CH_SP;
               n = 4;
            end
            lned_pkg::OP_READ: begin
               rd = (int'(idx) < lned_pkg::LINE_CAPACITY) ? line_copy[idx] : 8'h00;
            end
            default: begin
               n = 1;
            end
         endcase
         for (int k = 0; k < n; k++) begin
            rec.echo_on     = on;
            rec.echo_byte   = on ? seq[k] : 8'h00;
            rec.read_data   = rd;
            rec.line_ready  = ready;
            rec.line_length = fill[6:0];
            rec.tail        = (k == n - 1);
            echo_due.push_back(rec);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // Check one accepted result against the oldest expectation
      function void check_echo(logic [23:0] data, logic user, logic tail);
         echo_rec_type want;
         if (echo_due.size() == 0) begin
            $error("result with nothing expected: data 0x%0h user %0b last %0b",
                   data, user, tail);
            errors++;
            return;
         end
         want = echo_due.pop_front();
         n_results++;
         compare_field("echo_valid", want.echo_on, user);
         compare_field("echo_byte", want.echo_byte, data[7:0]);
         compare_field("read_data", want.read_data, data[15:8]);
         compare_field("line_ready", want.line_ready, data[16]);
         compare_field("line_length", want.line_length, data[23:17]);
         compare_field("last", want.tail, tail);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   bit          no_idle;
   echo_tracker board;

   line_editor_receive DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(logic [1:0] op, logic [7:0] b, logic [6:0] idx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {7'd0, idx, b, op};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      board.take_item(op, b, idx);
      @(negedge clock);
   endtask

   // Hold off the sender until every owed result has come back
   task automatic drain_results();
      req_tvalid = 1'b0;
      while (board.echo_due.size() > 0) @(negedge clock);
   endtask

   // Random index into the part of the store that has been written
   function automatic logic [6:0] written_index();
      return 7'($urandom_range(0, board.peak_fill - 1));
   endfunction

   // Byte that is neither printable nor an editing key
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ((b >= lned_pkg::CH_SP && b <= lned_pkg::CH_DEL) || b == lned_pkg::CH_CR ||
          b == lned_pkg::CH_LF || b == lned_pkg::CH_BS)
         b = b | 8'h80;
      return b;
   endfunction

   // Any item at all, with reads kept inside the written store
   task automatic send_noise();
      logic [1:0] op;
      op = 2'($urandom_range(0, 3));
      if (op == lned_pkg::OP_READ && board.peak_fill == 0) op = OP_UNUSED;
      send_item(op, 8'($urandom_range(0, 255)),
                op == lned_pkg::OP_READ ? written_index() : 7'($urandom_range(0, 127)));
   endtask

   // Type a line with edits and junk, end it, read it back, maybe release it
   task automatic type_line(int n_chars, bit clean);
      int r;
      if ($urandom_range(0, 3) != 0)
         send_item(lned_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)));
      for (int i = 0; i < n_chars; i++) begin
         r = clean ? 99 : $urandom_range(0, 99);
         if (r < 8)
            send_item(lned_pkg::OP_RECV, r[0] ? lned_pkg::CH_BS : lned_pkg::CH_DEL,
                      7'($urandom_range(0, 127)));
         else if (r < 13)
            send_item(lned_pkg::OP_RECV, noise_byte(), 7'($urandom_range(0, 127)));
         else if (r < 16 && board.peak_fill > 0)
            send_item(lned_pkg::OP_READ, 8'($urandom_range(0, 255)), written_index());
         else
            send_item(lned_pkg::OP_RECV,
                      8'($urandom_range(lned_pkg::CH_SP, lned_pkg::CH_TILDE)),
                      7'($urandom_range(0, 127)));
      end
      send_item(lned_pkg::OP_RECV, $urandom_range(0, 1) ? lned_pkg::CH_CR : lned_pkg::CH_LF,
                7'($urandom_range(0, 127)));
      if (clean && board.peak_fill > 0)
         send_item(lned_pkg::OP_READ, 8'($urandom_range(0, 255)), 7'(board.peak_fill - 1));
      repeat ($urandom_range(0, 3)) begin
         if (board.peak_fill > 0)
            send_item(lned_pkg::OP_READ, 8'($urandom_range(0, 255)), written_index());
      end
      // bytes that land while the line waits
      repeat ($urandom_range(0, 2))
         send_item(lned_pkg::OP_RECV, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      if ($urandom_range(0, 4) == 0)
         send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      if ($urandom_range(0, 5) != 0)
         send_item(lned_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                   7'($urandom_range(0, 127)));
   endtask

   // Result side: random stall before each result, then check it
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_echo(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
      end
   end

   // Stop the run when nothing moves for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("line_editor_receive: mismatch");
      $finish;
   end

   initial begin
      int sessions;
      board      = new();
      no_idle    = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = 24'd0;
      reset      = 1'b1;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: empty-line prompt, byte classes, edits, reads, ready line, release
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_CR, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_BS, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_SP, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_TILDE, 7'd0);
      send_item(lned_pkg::OP_RECV, 8'h1F, 7'd0);
      send_item(lned_pkg::OP_RECV, 8'h80, 7'd0);
      send_item(lned_pkg::OP_RECV, 8'hFF, 7'h7F);
      send_item(lned_pkg::OP_RECV, 8'h00, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_DEL, 7'd0);
      send_item(lned_pkg::OP_RECV, 8'h41, 7'd0);
      send_item(lned_pkg::OP_READ, 8'hFF, 7'd0);
      send_item(lned_pkg::OP_READ, 8'h00, 7'd1);
      send_item(OP_UNUSED, 8'hFF, 7'h7F);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_LF, 7'd0);
      send_item(lned_pkg::OP_RECV, 8'h78, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_CR, 7'd0);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_DEL, 7'd0);
      send_item(lned_pkg::OP_READ, 8'h00, 7'd0);
      send_item(lned_pkg::OP_RELEASE, 8'h00, 7'd0);
      send_item(lned_pkg::OP_READ, 8'h00, 7'd1);
      send_item(lned_pkg::OP_RELEASE, 8'hFF, 7'h7F);
      send_item(lned_pkg::OP_RECV, lned_pkg::CH_LF, 7'd0);
      drain_results();

      // Random: mostly typed lines, some loose items, and long lines typed near or past capacity
      sessions = 0;
      while (board.n_items < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if (sessions == 2 || ($urandom_range(0, 49) == 0 &&
             board.n_items + lned_pkg::LINE_CAPACITY + 24 < ITEM_TARGET))
            type_line($urandom_range(lned_pkg::LINE_CAPACITY - 8,
                                     lned_pkg::LINE_CAPACITY + 6), 1'b1);
         else if ($urandom_range(0, 4) != 0)
            type_line($urandom_range(0, 12), 1'b0);
         else
            repeat ($urandom_range(1, 6)) send_noise();
         sessions++;
         if (sessions % 10 == 0) drain_results();
      end

      // Let the last results out, then allow for stragglers
      drain_results();
      no_idle = 1'b1;
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d items (%0d typed lines), checked %0d results.",
               board.n_items, board.n_lines, board.n_results);
      $display("Store filled up to %0d bytes; %0d field errors.",
               board.peak_fill, board.errors);
      if (board.errors == 0 && board.echo_due.size() == 0)
         $display("line_editor_receive: match");
      else
         $display("line_editor_receive: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
